// File: rtl/acbc_pkg.sv
// Package for the CBC block cipher engine: beat types, register codes,
// S-box tables and the byte-level round functions. No dependencies.
package acbc_pkg;

  localparam int MAX_ROUNDS_DEF = 14;
  localparam int ROUND_W        = 4;

  typedef struct packed {
    logic [63:0] data_high;
    logic [63:0] data_low;
    logic        msg_start;
    logic [4:0]  byte_count;
  } in_item_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } out_item_t;

  typedef enum logic [2:0] {
    REG_KEY_MODE    = 3'd0,
    REG_ROUND_COUNT = 3'd1,
    REG_DIRECTION   = 3'd2,
    REG_KEY_WORD_0  = 3'd3,
    REG_KEY_WORD_1  = 3'd4,
    REG_KEY_WORD_2  = 3'd5,
    REG_KEY_WORD_3  = 3'd6
  } cfg_reg_t;

  localparam logic [1:0] KEY_MODE_INVALID = 2'd3;

  typedef struct packed {
    logic [1:0]       key_mode;
    logic [3:0][63:0] key_word;
  } ks_cfg_t;

  typedef struct packed {
    logic start;
    logic rd_en;
  } ks_cmd_t;

  typedef struct packed {
    logic load;
    logic step;
    logic init;
    logic last;
    logic decrypt;
    logic finish;
  } dp_cmd_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  localparam logic [3:0] FWD_COEF [4] = '{4'h2, 4'h3, 4'h1, 4'h1};
  localparam logic [3:0] INV_COEF [4] = '{4'he, 4'hb, 4'hd, 4'h9};
  localparam logic [7:0] RC_POLY = 8'h1b;

  function automatic logic [7:0] xtime(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? RC_POLY : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] v, input logic [3:0] m);
    logic [7:0] acc;
    logic [7:0] p;
    acc = 8'h00;
    p   = v;
    for (int i = 0; i < 4; i++) begin
      if (m[i]) acc = acc ^ p;
      p = xtime(p);
    end
    return acc;
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // byte i of the state sits at [127-8i -: 8], column i/4, row i%4
  function automatic logic [127:0] subst_state(input logic [127:0] s, input logic inv);
    logic [127:0] o;
    o = '0;
    for (int i = 0; i < 16; i++)
      o[127-8*i -: 8] = inv ? INV_SBOX[s[127-8*i -: 8]] : SBOX[s[127-8*i -: 8]];
    return o;
  endfunction

  function automatic logic [127:0] rotate_state(input logic [127:0] s, input logic inv);
    logic [127:0] o;
    int f;
    o = s;
    for (int r = 1; r < 4; r++)
      for (int c = 0; c < 4; c++) begin
        f = inv ? ((c + 4 - r) % 4) : ((c + r) % 4);
        o[127-8*(c*4+r) -: 8] = s[127-8*(f*4+r) -: 8];
      end
    return o;
  endfunction

  function automatic logic [127:0] mix_state(input logic [127:0] s, input logic inv);
    logic [127:0] o;
    logic [7:0]   acc;
    o = '0;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) begin
        acc = 8'h00;
        for (int k = 0; k < 4; k++)
          acc = acc ^ gmul(s[127-8*(c*4+k) -: 8],
                           inv ? INV_COEF[(k + 4 - r) % 4] : FWD_COEF[(k + 4 - r) % 4]);
        o[127-8*(c*4+r) -: 8] = acc;
      end
    return o;
  endfunction

endpackage

// File: rtl/acbc_keysched.sv
// Key expansion, one schedule word per cycle, into a row-wide round-key RAM.
// Depends on acbc_pkg.
module acbc_keysched #(
  parameter int MAX_ROUNDS = acbc_pkg::MAX_ROUNDS_DEF,
  parameter int ROW_W      = $clog2(MAX_ROUNDS + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  acbc_pkg::ks_cfg_t cfg,
  input  acbc_pkg::ks_cmd_t cmd,
  input  logic [ROW_W-1:0]  rd_row,
  output logic              busy,
  output logic [127:0]      key_row
);
  import acbc_pkg::*;

  localparam int ROWS  = MAX_ROUNDS + 1;
  localparam int WORDS = 4 * ROWS;
  localparam int IDX_W = $clog2(WORDS);

  logic [127:0]     mem [ROWS];
  logic [IDX_W-1:0] idx;
  logic [2:0]       pos;
  logic [7:0]       rc;
  logic [7:0][31:0] win;

  logic [3:0]  nk;
  logic [31:0] t;
  logic [31:0] w;
  logic [31:0] kw;
  logic        rot_step;

  always_comb begin
    nk       = 4'd4 + {1'b0, cfg.key_mode, 1'b0};
    kw       = idx[0] ? cfg.key_word[idx[2:1]][31:0] : cfg.key_word[idx[2:1]][63:32];
    rot_step = (pos == 3'd0);
    t        = win[0];
    if (rot_step)
      t = sub_word({win[0][23:0], win[0][31:24]}) ^ {rc, 24'h0};
    else if (nk == 4'd8 && pos == 3'd4)
      t = sub_word(win[0]);
    if (idx < IDX_W'(nk))
      w = kw;
    else
      w = win[nk[2:0] - 3'd1] ^ t;
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.start) begin
      busy <= 1'b1;
      idx  <= '0;
      pos  <= '0;
      rc   <= 8'h01;
    end else if (busy) begin
      idx <= idx + 1'b1;
      pos <= (pos == nk[2:0] - 3'd1) ? 3'd0 : pos + 3'd1;
      if (rot_step && idx >= IDX_W'(nk)) rc <= xtime(rc);
      if (idx == IDX_W'(WORDS - 1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      win <= {win[6:0], w};
      if (idx[1:0] == 2'd3) mem[idx[IDX_W-1:2]] <= {win[2], win[1], win[0], w};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en && 32'(rd_row) < ROWS) key_row <= mem[rd_row];
  end

endmodule

// File: rtl/acbc_datapath.sv
// Cipher state, chaining registers and the result register.
// Depends on acbc_pkg.
module acbc_datapath (
  input  logic               clk,
  input  logic               rst,
  input  acbc_pkg::dp_cmd_t  cmd,
  input  acbc_pkg::in_item_t in_data,
  input  logic [127:0]       key_row,
  output acbc_pkg::out_item_t out_data
);
  import acbc_pkg::*;

  logic [127:0] st;
  logic [127:0] chn;
  logic [127:0] ct;
  logic [127:0] chain;

  logic [127:0] blk;
  logic [127:0] chn_sel;
  logic [127:0] padded;
  logic [127:0] t;
  logic [127:0] st_next;

  always_comb begin
    blk     = {in_data.data_high, in_data.data_low};
    chn_sel = in_data.msg_start ? '0 : chain;
    padded  = '0;
    t       = '0;
    for (int i = 0; i < 16; i++)
      if (5'(i) < in_data.byte_count) padded[127-8*i -: 8] = blk[127-8*i -: 8];
    if (cmd.init) begin
      st_next = st ^ key_row;
    end else if (!cmd.decrypt) begin
      t       = rotate_state(subst_state(st, 1'b0), 1'b0);
      st_next = (cmd.last ? t : mix_state(t, 1'b0)) ^ key_row;
    end else begin
      t       = subst_state(rotate_state(st, 1'b1), 1'b1) ^ key_row;
      st_next = cmd.last ? t : mix_state(t, 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      chn <= chn_sel;
      ct  <= blk;
      st  <= cmd.decrypt ? blk : (padded ^ chn_sel);
    end else if (cmd.step) begin
      st <= st_next;
    end
    if (cmd.finish) out_data <= cmd.decrypt ? (st ^ chn) : st;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain <= '0;
    end else if (cmd.finish) begin
      chain <= cmd.decrypt ? ct : st;
    end
  end

endmodule

// File: rtl/acbc_ctrl.sv
// Controller: configuration registers, round sequencing, key-row addressing
// and output handshake. Depends on acbc_pkg.
module acbc_ctrl #(
  parameter int MAX_ROUNDS = acbc_pkg::MAX_ROUNDS_DEF,
  parameter int ROW_W      = $clog2(MAX_ROUNDS + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [63:0]       cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  logic              ks_busy,
  output acbc_pkg::ks_cfg_t ks_cfg,
  output acbc_pkg::ks_cmd_t ks_cmd,
  output logic [ROW_W-1:0]  rd_row,
  output acbc_pkg::dp_cmd_t dp_cmd
);
  import acbc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_EXPAND = 4'b0010,
    ST_RUN    = 4'b0100,
    ST_DONE   = 4'b1000
  } state_t;

  state_t             state, state_next;
  logic [ROUND_W-1:0] cnt;
  logic [1:0]         key_mode;
  logic [ROUND_W-1:0] round_count;
  logic               direction;
  logic [3:0][63:0]   key_word;

  logic               cfg_fire;
  logic               key_write;
  logic [ROUND_W-1:0] rounds;
  logic [ROUND_W-1:0] row;
  logic               finish;

  always_comb begin
    cfg_fire  = cfg_valid && cfg_ready;
    key_write = 1'b0;
    case (cfg_reg_t'(cfg_index))
      REG_KEY_MODE, REG_KEY_WORD_0, REG_KEY_WORD_1,
      REG_KEY_WORD_2, REG_KEY_WORD_3: key_write = cfg_fire;
      default:                        key_write = 1'b0;
    endcase
    if (round_count == '0)
      rounds = ROUND_W'(1);
    else if (round_count > ROUND_W'(MAX_ROUNDS))
      rounds = ROUND_W'(MAX_ROUNDS);
    else
      rounds = round_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_mode    <= 2'd0;
      round_count <= ROUND_W'(10);
      direction   <= 1'b0;
      key_word    <= '0;
    end else if (cfg_fire) begin
      case (cfg_reg_t'(cfg_index))
        REG_KEY_MODE: begin
          if (cfg_data[1:0] != KEY_MODE_INVALID) begin
            key_mode    <= cfg_data[1:0];
            round_count <= ROUND_W'(10) + {1'b0, cfg_data[1:0], 1'b0};
          end
        end
        REG_ROUND_COUNT: round_count <= cfg_data[ROUND_W-1:0];
        REG_DIRECTION:   direction   <= cfg_data[0];
        REG_KEY_WORD_0:  key_word[0] <= cfg_data;
        REG_KEY_WORD_1:  key_word[1] <= cfg_data;
        REG_KEY_WORD_2:  key_word[2] <= cfg_data;
        REG_KEY_WORD_3:  key_word[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    finish     = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_valid)       state_next = ST_RUN;
        else if (key_write) state_next = ST_EXPAND;
      end
      ST_EXPAND: begin
        if (!ks_busy) state_next = ST_IDLE;
      end
      ST_RUN: begin
        if (cnt == rounds) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          finish     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_EXPAND;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_RUN) cnt <= cnt + 1'b1;
      else                 cnt <= '0;
      if (finish)         out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_comb begin
    if (state == ST_IDLE)
      row = direction ? rounds : '0;
    else
      row = direction ? (rounds - cnt - 1'b1) : (cnt + 1'b1);
    rd_row    = row[ROW_W-1:0];
    // an offered input beat takes the idle cycle; registers wait for the next one
    cfg_ready = (state == ST_IDLE) && !in_valid;
    in_stall  = (state != ST_IDLE);

    ks_cfg.key_mode = key_mode;
    ks_cfg.key_word = key_word;
    ks_cmd.start    = key_write && !in_valid;
    ks_cmd.rd_en    = (state == ST_IDLE) || (state == ST_RUN);

    dp_cmd.load    = (state == ST_IDLE) && in_valid;
    dp_cmd.step    = (state == ST_RUN);
    dp_cmd.init    = (cnt == '0);
    dp_cmd.last    = (cnt == rounds);
    dp_cmd.decrypt = direction;
    dp_cmd.finish  = finish;
  end

endmodule

// File: rtl/aes_cbc_cipher_engine.sv
// CBC block cipher engine, AES rounds with 128/192/256-bit keys.
// Top level: controller, key schedule and datapath. Depends on acbc_pkg.
//
// Usage:
//   Input beats (in_valid/in_stall) carry one 128-bit block plus msg_start
//   and byte_count; each gives one output beat (out_valid/out_stall).
//   Registers are written on the cfg channel (cfg_valid/cfg_ready) while the
//   engine is idle; cfg_ready is high only in the idle state with no input
//   beat offered.
//   Writing key_mode or a key word starts key expansion: one schedule word
//   per cycle, 4*(MAX_ROUNDS+1) words (60 by default); the engine is idle
//   again once expansion ends, with in_stall held high until then.
//   Reset runs the same expansion from the reset key registers.
// Sequence:
//   With R effective rounds, a block is loaded on acceptance, gets the
//   initial round-key addition, then one round per cycle through the shared
//   round unit, then the result write; the next block is accepted only after
//   that, since the chaining of one block into the next needs its result.
//   The result sits in an output register; a new block is accepted while it
//   waits, and a finished block holds in the engine until the output
//   register frees up.
module aes_cbc_cipher_engine #(
  parameter int MAX_ROUNDS = acbc_pkg::MAX_ROUNDS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [63:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  acbc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output acbc_pkg::out_item_t out_data
);
  import acbc_pkg::*;

  localparam int ROW_W = $clog2(MAX_ROUNDS + 1);

  ks_cfg_t          ks_cfg;
  ks_cmd_t          ks_cmd;
  dp_cmd_t          dp_cmd;
  logic             ks_busy;
  logic [ROW_W-1:0] rd_row;
  logic [127:0]     key_row;

  acbc_ctrl #(
    .MAX_ROUNDS(MAX_ROUNDS),
    .ROW_W     (ROW_W)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .ks_busy  (ks_busy),
    .ks_cfg   (ks_cfg),
    .ks_cmd   (ks_cmd),
    .rd_row   (rd_row),
    .dp_cmd   (dp_cmd)
  );

  acbc_keysched #(
    .MAX_ROUNDS(MAX_ROUNDS),
    .ROW_W     (ROW_W)
  ) u_keysched (
    .clk    (clk),
    .rst    (rst),
    .cfg    (ks_cfg),
    .cmd    (ks_cmd),
    .rd_row (rd_row),
    .busy   (ks_busy),
    .key_row(key_row)
  );

  acbc_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (dp_cmd),
    .in_data (in_data),
    .key_row (key_row),
    .out_data(out_data)
  );

endmodule
